// File: hdl/hfl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package hfl_pkg;

  localparam int FRAME_LEN     = 64;
  localparam int TRANSFORM_LEN = 128;
  localparam int FL_W          = $clog2(FRAME_LEN);
  localparam int LOG_TL        = $clog2(TRANSFORM_LEN);
  localparam int BF_W          = LOG_TL - 1;
  localparam int ST_W          = $clog2(LOG_TL);
  localparam int SAMPLE_W      = 16;
  localparam int DATA_W        = 32;
  localparam int WIN_W         = 17;
  localparam int BIN_W         = 6;
  localparam int LOGP_W        = 16;
  localparam int DIV_W         = 8;
  localparam int Q_DEPTH       = 4;
  localparam int Q_PTR_W       = $clog2(Q_DEPTH);
  localparam bit HAS_PAD       = (FRAME_LEN < TRANSFORM_LEN);
  localparam logic [DIV_W-1:0] LOG_DIV_RESET = 8'd15;

  localparam int WIN_DEN = FRAME_LEN - 1;
  localparam int TW_DEN  = TRANSFORM_LEN;
  localparam int TS_DEN  = 4 * TRANSFORM_LEN;

  localparam logic [63:0]        ONE_Q30     = 64'd1073741824;
  localparam logic signed [63:0] ONE_Q30_S   = 64'sd1073741824;
  localparam logic [63:0]        HALF_PI_Q30 = 64'd1686629713;
  localparam logic signed [31:0] LOG10_2_Q32 = 32'sd1292913986;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic [FL_W-1:0]            idx;
    logic                       last;
  } hfl_word_t;

  typedef struct packed {
    logic [FL_W-1:0]          idx;
    logic                     last;
    logic signed [DATA_W-1:0] re;
    logic signed [DATA_W-1:0] im;
  } bin_req_t;

  typedef enum logic [3:0] {
    CS_COLLECT, CS_ZERO, CS_RD, CS_M0, CS_M1, CS_M2, CS_M3, CS_ADD, CS_WA, CS_WB,
    CS_BIN_RD, CS_BIN_SEND
  } core_state_t;

  typedef enum logic [3:0] {
    LS_IDLE, LS_SQA, LS_SQB, LS_ZCHK, LS_NORM, LS_SQR, LS_MUL, LS_PREP, LS_DIV,
    LS_FIX, LS_OUT
  } log_state_t;

  typedef logic [WIN_W-1:0]         win_tab_t [FRAME_LEN];
  typedef logic signed [DATA_W-1:0] tw_tab_t  [TRANSFORM_LEN];

  function automatic logic signed [63:0] cos_core(input logic [63:0] x);
    logic [63:0] y;
    logic [63:0] t;
    y = (x * x) >> 30;
    t = ONE_Q30;
    t = ONE_Q30 - ((y * t) >> 30) / 64'd132;
    t = ONE_Q30 - ((y * t) >> 30) / 64'd90;
    t = ONE_Q30 - ((y * t) >> 30) / 64'd56;
    t = ONE_Q30 - ((y * t) >> 30) / 64'd30;
    t = ONE_Q30 - ((y * t) >> 30) / 64'd12;
    return ONE_Q30_S - $signed(((y * t) >> 30) / 64'd2);
  endfunction

  function automatic logic signed [63:0] quad_cos(input logic [1:0] q, input logic [63:0] x);
    logic [63:0] comp;
    comp = HALF_PI_Q30 - x;
    unique case (q)
      2'd0: return cos_core(x);
      2'd1: return -cos_core(comp);
      2'd2: return -cos_core(x);
      default: return cos_core(comp);
    endcase
  endfunction

  function automatic logic [WIN_W-1:0] win_coef(input int i);
    logic [63:0]        n;
    logic [63:0]        q;
    logic [63:0]        r;
    logic [63:0]        x;
    logic signed [63:0] c;
    logic signed [63:0] num;
    logic signed [63:0] w;
    n   = 64'(i) % 64'(WIN_DEN);
    q   = (64'd4 * n) / 64'(WIN_DEN);
    r   = 64'd4 * n - q * 64'(WIN_DEN);
    x   = HALF_PI_Q30 * r / 64'(WIN_DEN);
    c   = quad_cos(q[1:0], x);
    num = 64'sd54 * ONE_Q30_S - 64'sd46 * c;
    w   = (num + 64'sd1638400) / 64'sd3276800;
    return w[WIN_W-1:0];
  endfunction

  function automatic logic signed [DATA_W-1:0] tw_cos_val(input int k);
    logic [63:0]        n;
    logic [63:0]        q;
    logic [63:0]        r;
    logic [63:0]        x;
    logic signed [63:0] c;
    n = 64'(k) % 64'(TW_DEN);
    q = (64'd4 * n) / 64'(TW_DEN);
    r = 64'd4 * n - q * 64'(TW_DEN);
    x = HALF_PI_Q30 * r / 64'(TW_DEN);
    c = quad_cos(q[1:0], x);
    return c[DATA_W-1:0];
  endfunction

  function automatic logic signed [DATA_W-1:0] tw_sin_val(input int k);
    logic [63:0]        n;
    logic [63:0]        q;
    logic [63:0]        r;
    logic [63:0]        x;
    logic signed [63:0] c;
    n = (64'd4 * 64'(k) + 64'd3 * 64'(TRANSFORM_LEN)) % 64'(TS_DEN);
    q = (64'd4 * n) / 64'(TS_DEN);
    r = 64'd4 * n - q * 64'(TS_DEN);
    x = HALF_PI_Q30 * r / 64'(TS_DEN);
    c = quad_cos(q[1:0], x);
    return c[DATA_W-1:0];
  endfunction

  function automatic win_tab_t build_win();
    win_tab_t t;
    for (int i = 0; i < FRAME_LEN; i++) t[i] = win_coef(i);
    return t;
  endfunction

  function automatic tw_tab_t build_tw_cos();
    tw_tab_t t;
    for (int k = 0; k < TRANSFORM_LEN; k++) t[k] = tw_cos_val(k);
    return t;
  endfunction

  function automatic tw_tab_t build_tw_sin();
    tw_tab_t t;
    for (int k = 0; k < TRANSFORM_LEN; k++) t[k] = tw_sin_val(k);
    return t;
  endfunction

  localparam win_tab_t WIN_TAB    = build_win();
  localparam tw_tab_t  TW_COS_TAB = build_tw_cos();
  localparam tw_tab_t  TW_SIN_TAB = build_tw_sin();

  function automatic logic [LOG_TL-1:0] bitrev(input logic [LOG_TL-1:0] v);
    logic [LOG_TL-1:0] r;
    for (int b = 0; b < LOG_TL; b++) r[LOG_TL-1-b] = v[b];
    return r;
  endfunction

  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [DATA_W+2:0] v);
    if (v > 35'sd2147483647) return 32'sh7fffffff;
    if (v < -35'sd2147483648) return 32'sh80000000;
    return v[DATA_W-1:0];
  endfunction

endpackage
`default_nettype wire

// File: hdl/hfl_front.sv
`timescale 1ns / 1ps
`default_nettype none
module hfl_front import hfl_pkg::*; (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic signed [SAMPLE_W-1:0] in_pcm_sample,
  output logic                            push_valid,
  input  wire logic                       push_ready,
  output hfl_word_t                       push_word
);

  logic [FL_W-1:0] fill_r, fill_nxt;
  logic            at_end;

  assign at_end     = (fill_r == FL_W'(FRAME_LEN - 1));
  assign in_ready   = push_ready;
  assign push_valid = in_valid;

  always_comb begin
    push_word.sample = in_pcm_sample;
    push_word.idx    = fill_r;
    push_word.last   = at_end;
    fill_nxt         = fill_r;
    if (in_valid && push_ready) begin
      fill_nxt = at_end ? '0 : fill_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else begin
      fill_r <= fill_nxt;
    end
  end

endmodule
`default_nettype wire

// File: hdl/hfl_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
module hfl_fifo import hfl_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      push_valid,
  output logic           push_ready,
  input  wire hfl_word_t push_word,
  output logic           pop_valid,
  input  wire logic      pop_ready,
  output hfl_word_t      pop_word
);

  hfl_word_t            store [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_r, rd_r;
  logic [Q_PTR_W:0]     cnt_r;
  logic                 do_push, do_pop;

  assign push_ready = (cnt_r != (Q_PTR_W + 1)'(Q_DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_word   = store[rd_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      store[wr_r] <= push_word;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) wr_r <= wr_r + 1'b1;
      if (do_pop) rd_r <= rd_r + 1'b1;
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// File: hdl/hfl_core.sv
`timescale 1ns / 1ps
`default_nettype none
module hfl_core import hfl_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      q_valid,
  output logic           q_ready,
  input  wire hfl_word_t q_word,
  output logic           req_valid,
  input  wire logic      req_ready,
  output bin_req_t       req
);

  core_state_t state_r, state_nxt;

  logic [2*DATA_W-1:0] work [TRANSFORM_LEN];
  logic [2*DATA_W-1:0] rd_a_q, rd_b_q;
  logic                rd_en;
  logic [LOG_TL-1:0]   ra, rb, wa;
  logic [2*DATA_W-1:0] wd;
  logic                we;

  logic                       ld_v_r, ld_last_r;
  logic signed [SAMPLE_W-1:0] ld_x_r;
  logic [FL_W-1:0]            ld_i_r;
  logic [LOG_TL-1:0]          zc_r, zc_nxt;
  logic [ST_W-1:0]            st_r, st_nxt;
  logic [BF_W-1:0]            bf_r, bf_nxt;
  logic [FL_W-1:0]            k_r, k_nxt;
  logic signed [DATA_W-1:0]   tw_c_r, tw_s_r;
  logic signed [63:0]         p0_r, p1_r, p2_r, p3_r;
  logic signed [DATA_W+1:0]   tr_r, ti_r;

  logic [LOG_TL-1:0]          bf_ext, half, jj, a_addr, b_addr, w_idx;
  logic signed [DATA_W-1:0]   ar, ai, br, bi, mul_x, mul_y;
  logic signed [63:0]         prod, t_re, t_im;
  logic signed [SAMPLE_W+WIN_W:0] wprod, wround;

  assign bf_ext = LOG_TL'(bf_r);
  assign half   = LOG_TL'(1) << st_r;
  assign jj     = bf_ext & (half - 1'b1);
  assign a_addr = (((bf_ext >> st_r) << 1) << st_r) | jj;
  assign b_addr = a_addr | half;
  assign w_idx  = jj << (ST_W'(LOG_TL - 1) - st_r);

  assign ar = $signed(rd_a_q[2*DATA_W-1:DATA_W]);
  assign ai = $signed(rd_a_q[DATA_W-1:0]);
  assign br = $signed(rd_b_q[2*DATA_W-1:DATA_W]);
  assign bi = $signed(rd_b_q[DATA_W-1:0]);

  assign mul_x = (state_r == CS_M0 || state_r == CS_M3) ? br : bi;
  assign mul_y = (state_r == CS_M0 || state_r == CS_M2) ? tw_c_r : tw_s_r;
  assign prod  = 64'(mul_x) * 64'(mul_y);
  assign t_re  = (p0_r + p1_r + 64'sd536870912) >>> 30;
  assign t_im  = (p2_r - p3_r + 64'sd536870912) >>> 30;

  assign wprod  = (SAMPLE_W + WIN_W + 1)'(ld_x_r) *
                  $signed({1'b0, WIN_TAB[ld_i_r]});
  assign wround = (wprod + 34'sd16) >>> 5;

  assign ra    = (state_r == CS_BIN_RD) ? LOG_TL'(k_r) : a_addr;
  assign rb    = b_addr;
  assign rd_en = (state_r == CS_RD) || (state_r == CS_BIN_RD);

  assign req.idx  = k_r;
  assign req.last = (k_r == FL_W'(FRAME_LEN - 1));
  assign req.re   = ar;
  assign req.im   = ai;

  always_ff @(posedge clk) begin
    if (we) work[wa] <= wd;
    if (rd_en) begin
      rd_a_q <= work[ra];
      rd_b_q <= work[rb];
    end
  end

  always_comb begin
    state_nxt = state_r;
    q_ready   = 1'b0;
    req_valid = 1'b0;
    we        = 1'b0;
    wa        = a_addr;
    wd        = '0;
    zc_nxt    = zc_r;
    st_nxt    = st_r;
    bf_nxt    = bf_r;
    k_nxt     = k_r;
    unique case (state_r)
      CS_COLLECT: begin
        q_ready = !(ld_v_r && ld_last_r);
        if (ld_v_r) begin
          we = 1'b1;
          wa = bitrev(LOG_TL'(ld_i_r));
          wd = {wround[DATA_W-1:0], {DATA_W{1'b0}}};
          if (ld_last_r) state_nxt = HAS_PAD ? CS_ZERO : CS_RD;
        end
      end
      CS_ZERO: begin
        we = 1'b1;
        wa = bitrev(zc_r);
        if (zc_r == LOG_TL'(TRANSFORM_LEN - 1)) begin
          zc_nxt    = LOG_TL'(FRAME_LEN);
          state_nxt = CS_RD;
        end else begin
          zc_nxt = zc_r + 1'b1;
        end
      end
      CS_RD:  state_nxt = CS_M0;
      CS_M0:  state_nxt = CS_M1;
      CS_M1:  state_nxt = CS_M2;
      CS_M2:  state_nxt = CS_M3;
      CS_M3:  state_nxt = CS_ADD;
      CS_ADD: state_nxt = CS_WA;
      CS_WA: begin
        we = 1'b1;
        wa = a_addr;
        wd = {sat32(35'(ar) + 35'(tr_r)), sat32(35'(ai) + 35'(ti_r))};
        state_nxt = CS_WB;
      end
      CS_WB: begin
        we = 1'b1;
        wa = b_addr;
        wd = {sat32(35'(ar) - 35'(tr_r)), sat32(35'(ai) - 35'(ti_r))};
        state_nxt = CS_RD;
        if (bf_r == {BF_W{1'b1}}) begin
          bf_nxt = '0;
          if (st_r == ST_W'(LOG_TL - 1)) begin
            st_nxt    = '0;
            k_nxt     = '0;
            state_nxt = CS_BIN_RD;
          end else begin
            st_nxt = st_r + 1'b1;
          end
        end else begin
          bf_nxt = bf_r + 1'b1;
        end
      end
      CS_BIN_RD: state_nxt = CS_BIN_SEND;
      CS_BIN_SEND: begin
        req_valid = 1'b1;
        if (req_ready) begin
          if (req.last) begin
            k_nxt     = '0;
            state_nxt = CS_COLLECT;
          end else begin
            k_nxt     = k_r + 1'b1;
            state_nxt = CS_BIN_RD;
          end
        end
      end
      default: state_nxt = CS_COLLECT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= CS_COLLECT;
      ld_v_r  <= 1'b0;
      zc_r    <= LOG_TL'(FRAME_LEN);
      st_r    <= '0;
      bf_r    <= '0;
      k_r     <= '0;
    end else begin
      state_r <= state_nxt;
      ld_v_r  <= q_valid && q_ready;
      zc_r    <= zc_nxt;
      st_r    <= st_nxt;
      bf_r    <= bf_nxt;
      k_r     <= k_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_valid && q_ready) begin
      ld_x_r    <= q_word.sample;
      ld_i_r    <= q_word.idx;
      ld_last_r <= q_word.last;
    end
    if (state_r == CS_RD) begin
      tw_c_r <= TW_COS_TAB[w_idx];
      tw_s_r <= TW_SIN_TAB[w_idx];
    end
    if (state_r == CS_M0) p0_r <= prod;
    if (state_r == CS_M1) p1_r <= prod;
    if (state_r == CS_M2) p2_r <= prod;
    if (state_r == CS_M3) p3_r <= prod;
    if (state_r == CS_ADD) begin
      tr_r <= t_re[DATA_W+1:0];
      ti_r <= t_im[DATA_W+1:0];
    end
  end

endmodule
`default_nettype wire

// File: hdl/hfl_log.sv
`timescale 1ns / 1ps
`default_nettype none
module hfl_log import hfl_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic [DIV_W-1:0] log_divisor,
  input  wire logic             req_valid,
  output logic                  req_ready,
  input  wire bin_req_t         req,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic [BIN_W-1:0]      out_bin_index,
  output logic [LOGP_W-1:0]     out_log_power,
  output logic                  out_last_bin
);

  log_state_t state_r, state_nxt;

  logic [DATA_W-1:0]  ur_r, ui_r, m_r;
  logic [FL_W-1:0]    idx_r;
  logic               last_r, neg_r;
  logic [63:0]        p_r;
  logic [5:0]         e_r;
  logic [4:0]         cnt_r;
  logic [15:0]        frac_r;
  logic signed [54:0] v_r;
  logic [19:0]        dq_r;
  logic [DIV_W-1:0]   rem_r;
  logic [LOGP_W-1:0]  res_r;

  logic                  out_valid_r, out_last_r;
  logic [BIN_W-1:0]      out_idx_r;
  logic [LOGP_W-1:0]     out_pow_r;

  logic [DATA_W-1:0]  mul_a;
  logic [63:0]        mprod, sq;
  logic [6:0]         sh;
  logic               top_zero;
  logic [63:0]        p_sh;
  logic signed [22:0] l2;
  logic signed [55:0] u;
  logic signed [19:0] w;
  logic [DIV_W-1:0]   d_eff;
  logic [DIV_W:0]     rem_t;
  logic               ge;
  logic signed [21:0] qv;
  logic               load_out;

  assign d_eff = (log_divisor == '0) ? DIV_W'(1) : log_divisor;

  always_comb begin
    unique case (state_r)
      LS_SQA:  mul_a = ur_r;
      LS_SQB:  mul_a = ui_r;
      default: mul_a = m_r;
    endcase
  end
  assign mprod = 64'(mul_a) * 64'(mul_a);
  assign sq    = mprod >> 30;

  assign sh       = 7'd32 >> cnt_r[2:0];
  assign top_zero = ((p_r & ~({64{1'b1}} >> sh)) == '0);
  assign p_sh     = top_zero ? (p_r << sh) : p_r;

  assign l2 = $signed({7'(e_r) - 7'd20, frac_r});
  assign u  = 56'(v_r) + $signed({13'd0, d_eff, 35'd0});
  assign w  = u[55:36];

  assign rem_t = {rem_r, dq_r[19]};
  assign ge    = (rem_t >= {1'b0, d_eff});

  assign qv = neg_r ? -($signed({2'b00, dq_r}) + 22'(rem_r != '0))
                    : $signed({2'b00, dq_r});

  assign load_out = (state_r == LS_OUT) && (!out_valid_r || out_ready);

  assign req_ready     = (state_r == LS_IDLE);
  assign out_valid     = out_valid_r;
  assign out_bin_index = out_idx_r;
  assign out_log_power = out_pow_r;
  assign out_last_bin  = out_last_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      LS_IDLE: if (req_valid) state_nxt = LS_SQA;
      LS_SQA:  state_nxt = LS_SQB;
      LS_SQB:  state_nxt = LS_ZCHK;
      LS_ZCHK: state_nxt = (p_r == '0) ? LS_OUT : LS_NORM;
      LS_NORM: if (cnt_r == 5'd5) state_nxt = LS_SQR;
      LS_SQR:  if (cnt_r == 5'd15) state_nxt = LS_MUL;
      LS_MUL:  state_nxt = LS_PREP;
      LS_PREP: state_nxt = LS_DIV;
      LS_DIV:  if (cnt_r == 5'd19) state_nxt = LS_FIX;
      LS_FIX:  state_nxt = LS_OUT;
      LS_OUT:  if (load_out) state_nxt = LS_IDLE;
      default: state_nxt = LS_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= LS_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_idx_r  <= BIN_W'(idx_r);
      out_pow_r  <= res_r;
      out_last_r <= last_r;
    end
    unique case (state_r)
      LS_IDLE: begin
        ur_r   <= req.re[DATA_W-1] ? DATA_W'(-req.re) : DATA_W'(req.re);
        ui_r   <= req.im[DATA_W-1] ? DATA_W'(-req.im) : DATA_W'(req.im);
        idx_r  <= req.idx;
        last_r <= req.last;
      end
      LS_SQA: p_r <= mprod;
      LS_SQB: p_r <= p_r + mprod;
      LS_ZCHK: begin
        e_r   <= 6'd63;
        cnt_r <= '0;
        res_r <= 16'h8000;
      end
      LS_NORM: begin
        p_r <= p_sh;
        if (top_zero) e_r <= e_r - sh[5:0];
        if (cnt_r == 5'd5) begin
          cnt_r  <= '0;
          m_r    <= {1'b0, p_sh[63:33]};
          frac_r <= '0;
        end else begin
          cnt_r <= cnt_r + 1'b1;
        end
      end
      LS_SQR: begin
        if (sq[31]) begin
          frac_r <= {frac_r[14:0], 1'b1};
          m_r    <= sq[32:1];
        end else begin
          frac_r <= {frac_r[14:0], 1'b0};
          m_r    <= sq[31:0];
        end
        cnt_r <= (cnt_r == 5'd15) ? '0 : cnt_r + 1'b1;
      end
      LS_MUL: v_r <= 55'(l2) * 55'(LOG10_2_Q32);
      LS_PREP: begin
        neg_r <= w[19];
        dq_r  <= w[19] ? 20'(-w) : 20'(w);
        rem_r <= '0;
        cnt_r <= '0;
      end
      LS_DIV: begin
        rem_r <= ge ? DIV_W'(rem_t - {1'b0, d_eff}) : rem_t[DIV_W-1:0];
        dq_r  <= {dq_r[18:0], ge};
        cnt_r <= (cnt_r == 5'd19) ? '0 : cnt_r + 1'b1;
      end
      LS_FIX: begin
        if (qv > 22'sd32767) begin
          res_r <= 16'h7fff;
        end else if (qv < -22'sd32768) begin
          res_r <= 16'h8000;
        end else begin
          res_r <= qv[LOGP_W-1:0];
        end
      end
      LS_OUT: ;
      default: ;
    endcase
  end

endmodule
`default_nettype wire

// File: hdl/hamming_fft_log_power_spectrum_top.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel  | ports                                           | dir
// ---------+-------------------------------------------------+-----
// input    | in_valid, in_ready, in_pcm_sample               | in
// result   | out_valid, out_ready, out_bin_index,            | out
//          | out_log_power, out_last_bin                     |
// config   | cfg_wr_en, cfg_wr_data (log_divisor)            | in
//
// Samples are taken one per cycle while the 4-word queue has room.
// Per frame: 64 samples collected, 64 zero-pad words, then 448 butterflies, each
// through RD, M0-M3, ADD, WA, WB (one work-memory write port); then the log unit
// runs per bin (16 squarings, 20-step divider).
// Synchronous active-low reset; the work memory needs no clearing pass.
// Either side may stall; results wait in the output register.
module hamming_fft_log_power_spectrum_top import hfl_pkg::*; (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic signed [SAMPLE_W-1:0] in_pcm_sample,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic [BIN_W-1:0]                out_bin_index,
  output logic signed [LOGP_W-1:0]        out_log_power,
  output logic                            out_last_bin,
  input  wire logic                       cfg_wr_en,
  input  wire logic [DIV_W-1:0]           cfg_wr_data
);

  logic [DIV_W-1:0] log_divisor_r;

  logic      push_valid, push_ready, pop_valid, pop_ready;
  hfl_word_t push_word, pop_word;
  logic      req_valid, req_ready;
  bin_req_t  req;
  logic [LOGP_W-1:0] log_power;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      log_divisor_r <= LOG_DIV_RESET;
    end else if (cfg_wr_en) begin
      log_divisor_r <= cfg_wr_data;
    end
  end

  hfl_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_pcm_sample (in_pcm_sample),
    .push_valid    (push_valid),
    .push_ready    (push_ready),
    .push_word     (push_word)
  );

  hfl_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_word  (push_word),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_word   (pop_word)
  );

  hfl_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (pop_valid),
    .q_ready   (pop_ready),
    .q_word    (pop_word),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req)
  );

  hfl_log u_log (
    .clk           (clk),
    .rst_n         (rst_n),
    .log_divisor   (log_divisor_r),
    .req_valid     (req_valid),
    .req_ready     (req_ready),
    .req           (req),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_bin_index (out_bin_index),
    .out_log_power (log_power),
    .out_last_bin  (out_last_bin)
  );

  assign out_log_power = $signed(log_power);

endmodule
`default_nettype wire

// File: sim/spectrum_checker.sv
`timescale 1ns / 1ps
module spectrum_checker import hfl_pkg::*; (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  input  wire logic                       in_ready,
  input  wire logic signed [SAMPLE_W-1:0] in_pcm_sample,
  input  wire logic                       out_valid,
  input  wire logic                       out_ready,
  input  wire logic [BIN_W-1:0]           out_bin_index,
  input  wire logic signed [LOGP_W-1:0]   out_log_power,
  input  wire logic                       out_last_bin,
  input  wire logic                       cfg_wr_en,
  input  wire logic [DIV_W-1:0]           cfg_wr_data,
  output int                              errors,
  output int                              bins_pending,
  output int                              bins_checked
);

  localparam longint unsigned ONE = 64'd1073741824;
  localparam longint unsigned QUARTER_TURN = 64'd1686629713;
  localparam longint LOG10_OF_2 = 64'sd1292913986;

  typedef struct {
    logic [BIN_W-1:0]         bin;
    logic signed [LOGP_W-1:0] power;
    logic                     last;
  } bin_word_t;

  bin_word_t           spectrum_q[$];
  logic [DIV_W-1:0]    divisor;
  logic signed [15:0]  frame[FRAME_LEN];
  int                  fill;
  longint unsigned     hamming[FRAME_LEN];
  longint              wr_cos[TRANSFORM_LEN];
  longint              wr_sin[TRANSFORM_LEN];

  function automatic longint taylor_cos(longint unsigned x);
    longint unsigned y, t;
    longint unsigned dv[5];
    dv = '{132, 90, 56, 30, 12};
    y = (x * x) >> 30;
    t = ONE;
    for (int i = 0; i < 5; i++) t = ONE - ((y * t) >> 30) / dv[i];
    return longint'(ONE) - longint'(((y * t) >> 30) / 2);
  endfunction

  function automatic longint cos_of_turn(longint unsigned num, longint unsigned den);
    longint unsigned q, rem, x;
    num = num % den;
    q = (4 * num) / den;
    rem = 4 * num - q * den;
    x = QUARTER_TURN * rem / den;
    case (q)
      0: return taylor_cos(x);
      1: return -taylor_cos(QUARTER_TURN - x);
      2: return -taylor_cos(x);
      default: return taylor_cos(QUARTER_TURN - x);
    endcase
  endfunction

  function automatic int clip32(longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return int'(v);
  endfunction

  function automatic longint floor_div(longint n, longint d);
    if (n >= 0) return n / d;
    return -((-n + d - 1) / d);
  endfunction

  function automatic logic signed [15:0] log_power_code(longint re, longint im,
                                                        logic [DIV_W-1:0] dv);
    longint unsigned ar, ai, p, m;
    int     e;
    longint frac, l2, den, q;
    ar = (re < 0) ? -re : re;
    ai = (im < 0) ? -im : im;
    p = ar * ar + ai * ai;
    if (p == 0) return -16'sd32768;
    e = 0;
    while (e < 63 && (p >> (e + 1)) != 0) e++;
    m = (e >= 30) ? (p >> (e - 30)) : (p << (30 - e));
    frac = 0;
    for (int i = 0; i < 16; i++) begin
      m = (m * m) >> 30;
      frac = frac << 1;
      if (m >= (64'd1 << 31)) begin
        frac = frac | 1;
        m = m >> 1;
      end
    end
    l2 = (longint'(e) - 20) * 65536 + frac;
    den = longint'((dv == 0) ? 1 : dv) << 36;
    q = floor_div(l2 * LOG10_OF_2 + den / 2, den);
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    return q[15:0];
  endfunction

  task automatic predict_spectrum();
    int re[TRANSFORM_LEN];
    int im[TRANSFORM_LEN];
    int r, a, b, w, half, stp, tmp;
    longint br, bi, tr, ti;
    bin_word_t wd;
    for (int i = 0; i < TRANSFORM_LEN; i++) begin
      im[i] = 0;
      re[i] = 0;
      if (i < FRAME_LEN)
        re[i] = int'((longint'(frame[i]) * longint'(hamming[i]) + 16) >>> 5);
    end
    for (int i = 0; i < TRANSFORM_LEN; i++) begin
      r = 0;
      for (int k = 0; k < LOG_TL; k++) if (i[k]) r |= 1 << (LOG_TL - 1 - k);
      if (r > i) begin
        tmp = re[i]; re[i] = re[r]; re[r] = tmp;
        tmp = im[i]; im[i] = im[r]; im[r] = tmp;
      end
    end
    for (int len = 2; len <= TRANSFORM_LEN; len = len * 2) begin
      half = len / 2;
      stp = TRANSFORM_LEN / len;
      for (int s = 0; s < TRANSFORM_LEN; s += len) begin
        for (int j = 0; j < half; j++) begin
          w = (j * stp) % TRANSFORM_LEN;
          a = s + j;
          b = a + half;
          br = re[b];
          bi = im[b];
          tr = (br * wr_cos[w] + bi * wr_sin[w] + (64'sd1 <<< 29)) >>> 30;
          ti = (bi * wr_cos[w] - br * wr_sin[w] + (64'sd1 <<< 29)) >>> 30;
          re[b] = clip32(longint'(re[a]) - tr);
          im[b] = clip32(longint'(im[a]) - ti);
          re[a] = clip32(longint'(re[a]) + tr);
          im[a] = clip32(longint'(im[a]) + ti);
        end
      end
    end
    for (int k = 0; k < FRAME_LEN; k++) begin
      wd.bin = BIN_W'(k);
      wd.power = log_power_code(re[k], im[k], divisor);
      wd.last = (k == FRAME_LEN - 1);
      spectrum_q.push_back(wd);
    end
  endtask

  task automatic report(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  initial begin
    longint c;
    errors = 0;
    bins_checked = 0;
    for (int i = 0; i < FRAME_LEN; i++) begin
      c = cos_of_turn(i, FRAME_LEN - 1);
      hamming[i] = (54 * longint'(ONE) - 46 * c + 1638400) / 3276800;
    end
    for (int k = 0; k < TRANSFORM_LEN; k++) begin
      wr_cos[k] = cos_of_turn(k, TRANSFORM_LEN);
      wr_sin[k] = cos_of_turn(4 * k + 3 * TRANSFORM_LEN, 4 * TRANSFORM_LEN);
    end
  end

  assign bins_pending = spectrum_q.size();

  always @(posedge clk) begin
    bin_word_t want;
    if (!rst_n) begin
      divisor = LOG_DIV_RESET;
      fill = 0;
      spectrum_q.delete();
    end else begin
      if (cfg_wr_en) divisor = cfg_wr_data;
      if (out_valid && out_ready) begin
        if (spectrum_q.size() == 0) begin
          report("unexpected word, bin", out_bin_index, -1);
        end else begin
          want = spectrum_q.pop_front();
          bins_checked++;
          if (out_bin_index !== want.bin) report("bin_index", out_bin_index, want.bin);
          if (out_log_power !== want.power) report("log_power", out_log_power, want.power);
          if (out_last_bin !== want.last) report("last_bin", out_last_bin, want.last);
        end
      end
      if (in_valid && in_ready) begin
        frame[fill] = in_pcm_sample;
        fill++;
        if (fill == FRAME_LEN) begin
          fill = 0;
          predict_spectrum();
        end
      end
    end
  end

  final if (spectrum_q.size() != 0) $display("%0d bins never arrived", spectrum_q.size());

endmodule

// File: sim/hamming_fft_log_power_spectrum_top_test.sv
`timescale 1ns / 1ps
module hamming_fft_log_power_spectrum_top_test;
  import hfl_pkg::*;

  logic                       clk;
  logic                       rst_n = 1'b0;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  logic signed [SAMPLE_W-1:0] in_pcm_sample = '0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic [BIN_W-1:0]           out_bin_index;
  logic signed [LOGP_W-1:0]   out_log_power;
  logic                       out_last_bin;
  logic                       cfg_wr_en = 1'b0;
  logic [DIV_W-1:0]           cfg_wr_data = '0;
  int                         errors, bins_pending, bins_checked;
  int                         gap_pct = 0, stall_pct = 0;
  int                         cycles = 0, words_sent = 0;
  localparam int CYCLE_LIMIT = 400000;

  hamming_fft_log_power_spectrum_top dut (.*);

  spectrum_checker u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("*** FAILED ***");
      $finish;
    end
  end

  always @(negedge clk) out_ready <= ($urandom_range(0, 99) >= stall_pct);

  task automatic send_word(logic signed [15:0] s);
    if ($urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_pcm_sample <= s;
    while (!in_ready) @(negedge clk);
    @(negedge clk);
    words_sent++;
  endtask

  task automatic drain();
    while (bins_pending != 0) @(negedge clk);
    repeat (200) @(negedge clk);
  endtask

  task automatic set_divisor(logic [DIV_W-1:0] d);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= d;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    @(negedge clk);
  endtask

  // style 0: silence, 1: full-scale extremes, 2: random, 3: small amplitude
  task automatic send_frame(int style);
    logic signed [15:0] s;
    for (int i = 0; i < FRAME_LEN; i++) begin
      case (style)
        0: s = 0;
        1: begin
          case (i % 6)
            0: s = 16'sh7fff;
            1: s = -16'sh8000;
            2: s = -1;
            3: s = 1;
            default: s = (i % 12 < 6) ? 16'sh7fff : -16'sh8000;
          endcase
        end
        2: s = 16'($urandom_range(0, 65535));
        default: s = $signed(16'($urandom_range(0, 63))) - 32;
      endcase
      if (style == 2 && $urandom_range(0, 15) == 0) s = $urandom_range(0, 1) ? 16'sh7fff : -16'sh8000;
      send_word(s);
    end
    in_valid <= 1'b0;
  endtask

  initial begin
    logic [DIV_W-1:0] divs[4];
    int styles[4];
    divs = '{15, 1, 0, 128};
    styles = '{0, 1, 2, 3};
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    for (int f = 0; f < 4; f++) begin
      case (f % 4)
        0: begin gap_pct = 0; stall_pct = 0; end
        1: begin gap_pct = 66; stall_pct = 0; end
        2: begin gap_pct = 0; stall_pct = 66; end
        default: begin gap_pct = 22; stall_pct = 22; end
      endcase
      if (f != 0) set_divisor(divs[f]);
      send_frame(styles[f]);
      drain();
    end
    // a partial frame left at the end must produce nothing
    for (int i = 0; i < 14; i++) send_word(16'($urandom_range(0, 65535)));
    in_valid <= 1'b0;
    drain();
    $display("sent %0d words in 4 frames plus a partial one, %0d bins checked", words_sent,
             bins_checked);
    $display("divisors 15,1,0,128; silence, full-scale, random and small frames");
    if (errors == 0 && bins_pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
